// ----- src/fcdma_pkg.sv -----
// Shared types, constants and helpers for the four-channel DMA controller.
// No dependencies.
`timescale 1ns / 1ps

package fcdma_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_BYTES = 12;

  typedef enum logic [2:0] {
    K_REG_WR  = 3'd0,
    K_REG_RD  = 3'd1,
    K_HBLANK  = 3'd2,
    K_VBLANK  = 3'd3,
    K_SUSPEND = 3'd4,
    K_RUN     = 3'd5,
    K_UNIT    = 3'd6,
    K_NOP     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_NONE = 2'd3
  } size_t;

  // Address-control codes
  localparam logic [1:0] AC_INC    = 2'd0;
  localparam logic [1:0] AC_DEC    = 2'd1;
  localparam logic [1:0] AC_FIXED  = 2'd2;
  localparam logic [1:0] AC_RELOAD = 2'd3;

  // Start timing codes
  localparam logic [1:0] ST_NOW    = 2'd0;
  localparam logic [1:0] ST_VBLANK = 2'd1;
  localparam logic [1:0] ST_HBLANK = 2'd2;

  // Bit positions within the 11-bit stored control (register bits 5..15)
  localparam int CB_REPEAT = 4;
  localparam int CB_WORD   = 5;
  localparam int CB_IRQ    = 9;
  localparam int CB_EN     = 10;

  localparam logic [16:0] CNT_MAX_CH3 = 17'h1_0000;
  localparam logic [16:0] CNT_MAX     = 17'h0_4000;

  typedef struct packed {
    logic       hit;
    logic [1:0] ch;
    logic [3:0] off;
  } dec_t;

  // Result item; first field highest.
  typedef struct packed {
    logic [3:0]  pad;
    logic [3:0]  active_mask;
    logic        done_res;
    logic        irq_pulse;
    logic        xfer_word;
    logic [31:0] xfer_dst;
    logic [31:0] xfer_src;
    logic        xfer_valid;
    logic [3:0]  open_bus_mask;
    logic [31:0] read_data;
  } res_t;

  // Split a flat byte address into channel and offset (divide by 12).
  function automatic dec_t decode(input logic [5:0] addr);
    dec_t d;
    d.hit = 1'b1;
    if (addr < 6'd12) begin
      d.ch = 2'd0; d.off = addr[3:0];
    end else if (addr < 6'd24) begin
      d.ch = 2'd1; d.off = 4'(addr - 6'd12);
    end else if (addr < 6'd36) begin
      d.ch = 2'd2; d.off = 4'(addr - 6'd24);
    end else if (addr < 6'd48) begin
      d.ch = 2'd3; d.off = 4'(addr - 6'd36);
    end else begin
      d.hit = 1'b0; d.ch = 2'd0; d.off = 4'd0;
    end
    return d;
  endfunction

  function automatic logic [16:0] count_load(input logic [15:0] wc, input logic [1:0] ch);
    if (wc == 16'd0) return (ch == 2'd3) ? CNT_MAX_CH3 : CNT_MAX;
    return {1'b0, wc};
  endfunction

  function automatic logic [3:0] step_for(input logic [1:0] ctl, input logic word);
    logic [3:0] mag;
    mag = word ? 4'd4 : 4'd2;
    if (ctl == AC_DEC) return 4'(4'd0 - mag);
    if (ctl == AC_FIXED) return 4'd0;
    return mag;
  endfunction

endpackage

// ----- src/four_channel_dma_controller_unit.sv -----
// Four-channel DMA controller: register file, trigger logic, element stepping.
// Depends on fcdma_pkg.
`timescale 1ns / 1ps
// An accepted input transaction is held in the input register, then goes through one
//   pass of logic into the result register, which drives m_tdata.
// Throughput: one transaction per cycle, with all state updated in one pass of logic.
//   A low m_tready holds the result register, and then the input register.
// Reset (rst, synchronous, active high) clears all channel registers, working
//   copies, steps and flags to zero and empties both pipeline registers.

module four_channel_dma_controller_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,  // channel[1:0], reg_offset[5:2], access_size[7:6],
                                 // write_data[39:8]
  input  logic [2:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata   // read_data, open_bus_mask, xfer_valid, xfer_src,
                                 // xfer_dst, xfer_word, irq_pulse, done_res,
                                 // active_mask, zero pad (lowest bit up)
);

  // ---- input register ----
  logic        in_valid;
  logic [2:0]  in_kind;
  logic [1:0]  in_ch;
  logic [3:0]  in_off;
  logic [1:0]  in_size;
  logic [31:0] in_wd;
  logic        proc;

  // proc: the held transaction moves into the result register this cycle
  assign proc     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_ch   <= s_tdata[1:0];
      in_off  <= s_tdata[5:2];
      in_size <= s_tdata[7:6];
      in_wd   <= s_tdata[39:8];
    end
  end

  // ---- channel state ----
  logic [31:0] src_base  [fcdma_pkg::NUM_CH];
  logic [31:0] dst_base  [fcdma_pkg::NUM_CH];
  logic [15:0] wcount    [fcdma_pkg::NUM_CH];
  logic [10:0] ctrl      [fcdma_pkg::NUM_CH];
  logic [16:0] wk_count  [fcdma_pkg::NUM_CH];
  logic [31:0] wk_src    [fcdma_pkg::NUM_CH];
  logic [31:0] wk_dst    [fcdma_pkg::NUM_CH];
  logic [3:0]  src_step  [fcdma_pkg::NUM_CH];
  logic [3:0]  dst_step  [fcdma_pkg::NUM_CH];
  logic [3:0]  engaged;
  logic [3:0]  paused;
  logic [3:0]  rpt_pend;

  logic [31:0] src_base_next [fcdma_pkg::NUM_CH];
  logic [31:0] dst_base_next [fcdma_pkg::NUM_CH];
  logic [15:0] wcount_next   [fcdma_pkg::NUM_CH];
  logic [10:0] ctrl_next     [fcdma_pkg::NUM_CH];
  logic [16:0] wk_count_next [fcdma_pkg::NUM_CH];
  logic [31:0] wk_src_next   [fcdma_pkg::NUM_CH];
  logic [31:0] wk_dst_next   [fcdma_pkg::NUM_CH];
  logic [3:0]  src_step_next [fcdma_pkg::NUM_CH];
  logic [3:0]  dst_step_next [fcdma_pkg::NUM_CH];
  logic [3:0]  engaged_next;
  logic [3:0]  paused_next;
  logic [3:0]  rpt_pend_next;

  fcdma_pkg::res_t res;
  fcdma_pkg::res_t res_q;

  always_comb begin
    logic [5:0]           addr;
    logic [5:0]           haddr;
    fcdma_pkg::dec_t      dd;
    logic [15:0]          hd;
    logic [7:0]           bd;
    logic                 ctl_we;
    logic [1:0]           ctl_ch;
    logic [10:0]          ctl_val;
    logic                 old_en;
    logic [15:0]          rhalf [2];
    logic [1:0]           ropen;
    logic [1:0]           c;

    src_base_next = src_base;
    dst_base_next = dst_base;
    wcount_next   = wcount;
    ctrl_next     = ctrl;
    wk_count_next = wk_count;
    wk_src_next   = wk_src;
    wk_dst_next   = wk_dst;
    src_step_next = src_step;
    dst_step_next = dst_step;
    engaged_next  = engaged;
    paused_next   = paused;
    rpt_pend_next = rpt_pend;
    res     = '0;
    ctl_we  = 1'b0;
    ctl_ch  = 2'd0;
    ctl_val = '0;
    old_en  = 1'b0;
    rhalf[0] = '0;
    rhalf[1] = '0;
    ropen    = '0;
    haddr    = '0;
    hd       = '0;
    bd       = in_wd[7:0];
    c        = in_ch;
    // flat byte address: channel * 12 + offset
    addr = 6'({in_ch, 3'b000} + {in_ch, 2'b00}) + 6'(in_off);
    dd   = fcdma_pkg::decode(addr);

    unique case (fcdma_pkg::kind_t'(in_kind))
      fcdma_pkg::K_REG_WR: begin
        if (fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_BYTE) begin
          if (dd.hit) begin
            priority if (dd.off < 4'd4) begin
              src_base_next[dd.ch][8*dd.off[1:0] +: 8] =
                (dd.off == 4'd3) ? {4'd0, bd[3:0]} : bd;
            end else if (dd.off < 4'd8) begin
              dst_base_next[dd.ch][8*dd.off[1:0] +: 8] =
                (dd.off == 4'd7) ? {4'd0, bd[3:0]} : bd;
            end else if (dd.off == 4'd8) begin
              wcount_next[dd.ch][7:0] = bd;
            end else if (dd.off == 4'd9) begin
              wcount_next[dd.ch][15:8] = (dd.ch == 2'd3) ? bd : {2'd0, bd[5:0]};
            end else if (dd.off == 4'd10) begin
              ctrl_next[dd.ch][2:0] = bd[7:5];
            end else begin
              ctl_we  = 1'b1;
              ctl_ch  = dd.ch;
              ctl_val = {bd, ctrl[dd.ch][2:0]};
            end
          end
        end else if (fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_HALF ||
                     fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_WORD) begin
          // a word goes as two halfwords, low then high
          for (int h = 0; h < 2; h++) begin
            haddr = addr + 6'(2 * h);
            hd    = (h == 0) ? in_wd[15:0] : in_wd[31:16];
            dd    = fcdma_pkg::decode(haddr);
            if ((h == 0 || fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_WORD) && dd.hit) begin
              unique case (dd.off)
                4'd0:  src_base_next[dd.ch][15:0]  = hd;
                4'd2:  src_base_next[dd.ch][31:16] = hd;
                4'd4:  dst_base_next[dd.ch][15:0]  = hd;
                4'd6:  dst_base_next[dd.ch][31:16] = hd;
                4'd8:  wcount_next[dd.ch]          = hd;
                4'd10: begin
                  ctl_we  = 1'b1;
                  ctl_ch  = dd.ch;
                  ctl_val = hd[15:5];
                end
                default: ;
              endcase
            end
          end
        end
        // control write last: its reload sees any count or address just written
        if (ctl_we) begin
          old_en = ctrl_next[ctl_ch][fcdma_pkg::CB_EN];
          ctrl_next[ctl_ch] = ctl_val;
          if (ctl_val[fcdma_pkg::CB_EN] != old_en) begin
            if (!old_en) begin
              paused_next[ctl_ch]   = 1'b0;
              rpt_pend_next[ctl_ch] = 1'b0;
              wk_count_next[ctl_ch] = fcdma_pkg::count_load(wcount_next[ctl_ch], ctl_ch);
              wk_dst_next[ctl_ch]   = dst_base_next[ctl_ch];
              wk_src_next[ctl_ch]   = src_base_next[ctl_ch];
              if (ctl_val[8:7] == fcdma_pkg::ST_NOW) engaged_next[ctl_ch] = 1'b1;
            end else begin
              engaged_next[ctl_ch] = 1'b0;
            end
          end
        end
      end

      fcdma_pkg::K_REG_RD: begin
        if (fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_BYTE) begin
          if (dd.hit && (dd.off == 4'd8 || dd.off == 4'd9)) begin
            res.read_data = '0;
          end else if (dd.hit && dd.off == 4'd10) begin
            res.read_data = {24'd0, ctrl[dd.ch][2:0], 5'd0};
          end else if (dd.hit && dd.off == 4'd11) begin
            res.read_data = {24'd0, ctrl[dd.ch][10:3]};
          end else begin
            res.open_bus_mask = 4'b0001;
          end
        end else if (fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_HALF ||
                     fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_WORD) begin
          for (int h = 0; h < 2; h++) begin
            haddr = addr + 6'(2 * h);
            dd    = fcdma_pkg::decode(haddr);
            if (dd.hit && dd.off == 4'd8) begin
              rhalf[h] = '0;
            end else if (dd.hit && dd.off == 4'd10) begin
              rhalf[h] = {ctrl[dd.ch], 5'd0};
            end else begin
              ropen[h] = 1'b1;
            end
          end
          if (fcdma_pkg::size_t'(in_size) == fcdma_pkg::SZ_WORD) begin
            res.read_data     = {rhalf[1], rhalf[0]};
            res.open_bus_mask = {ropen[1], ropen[1], ropen[0], ropen[0]};
          end else begin
            res.read_data     = {16'd0, rhalf[0]};
            res.open_bus_mask = {2'b00, ropen[0], ropen[0]};
          end
        end
      end

      fcdma_pkg::K_HBLANK, fcdma_pkg::K_VBLANK: begin
        for (int i = 0; i < fcdma_pkg::NUM_CH; i++) begin
          if (ctrl[i][fcdma_pkg::CB_EN] &&
              ctrl[i][8:7] == ((fcdma_pkg::kind_t'(in_kind) == fcdma_pkg::K_HBLANK) ?
                               fcdma_pkg::ST_HBLANK : fcdma_pkg::ST_VBLANK)) begin
            engaged_next[i] = 1'b1;
          end
        end
      end

      fcdma_pkg::K_SUSPEND: paused_next[c] = 1'b1;

      fcdma_pkg::K_RUN: begin
        if (paused[c]) begin
          paused_next[c] = 1'b0;
        end else begin
          if (rpt_pend[c]) begin
            wk_count_next[c] = fcdma_pkg::count_load(wcount[c], c);
            if (ctrl[c][1:0] == fcdma_pkg::AC_RELOAD) wk_dst_next[c] = dst_base[c];
            rpt_pend_next[c] = 1'b0;
          end
          dst_step_next[c] = fcdma_pkg::step_for(ctrl[c][1:0], ctrl[c][fcdma_pkg::CB_WORD]);
          src_step_next[c] = fcdma_pkg::step_for(ctrl[c][3:2], ctrl[c][fcdma_pkg::CB_WORD]);
        end
      end

      fcdma_pkg::K_UNIT: begin
        if (engaged[c] && wk_count[c] != 17'd0) begin
          res.xfer_valid   = 1'b1;
          res.xfer_src     = wk_src[c];
          res.xfer_dst     = wk_dst[c];
          res.xfer_word    = ctrl[c][fcdma_pkg::CB_WORD];
          wk_count_next[c] = wk_count[c] - 17'd1;
          wk_src_next[c]   = wk_src[c] + {{28{src_step[c][3]}}, src_step[c]};
          wk_dst_next[c]   = wk_dst[c] + {{28{dst_step[c][3]}}, dst_step[c]};
          if (wk_count[c] == 17'd1) begin
            res.done_res    = 1'b1;
            engaged_next[c] = 1'b0;
            res.irq_pulse   = ctrl[c][fcdma_pkg::CB_IRQ];
            if (ctrl[c][fcdma_pkg::CB_REPEAT]) rpt_pend_next[c] = 1'b1;
            else ctrl_next[c][fcdma_pkg::CB_EN] = 1'b0;
          end
        end
      end

      default: ;
    endcase

    res.active_mask = engaged_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcdma_pkg::NUM_CH; i++) begin
        src_base[i] <= '0;
        dst_base[i] <= '0;
        wcount[i]   <= '0;
        ctrl[i]     <= '0;
        wk_count[i] <= '0;
        wk_src[i]   <= '0;
        wk_dst[i]   <= '0;
        src_step[i] <= '0;
        dst_step[i] <= '0;
      end
      engaged  <= '0;
      paused   <= '0;
      rpt_pend <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (proc) begin
        src_base <= src_base_next;
        dst_base <= dst_base_next;
        wcount   <= wcount_next;
        ctrl     <= ctrl_next;
        wk_count <= wk_count_next;
        wk_src   <= wk_src_next;
        wk_dst   <= wk_dst_next;
        src_step <= src_step_next;
        dst_step <= dst_step_next;
        engaged  <= engaged_next;
        paused   <= paused_next;
        rpt_pend <= rpt_pend_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (proc) res_q <= res;
  end

  assign m_tdata = res_q;

  // ---- assertions ----
  a_done_has_xfer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.done_res |-> res_q.xfer_valid)
    else $error("done without an element copy");

  a_irq_has_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_q.irq_pulse |-> res_q.done_res)
    else $error("interrupt without completion");

  a_done_disengages: assert property (@(posedge clk) disable iff (rst)
    proc && res.done_res |=> !engaged[$past(in_ch)])
    else $error("channel still engaged after completion");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("input stalled with empty input register");

endmodule
